>>> src/md5_pkg.sv
package md5_pkg;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hefcdab89;
    localparam logic [31:0] IV2 = 32'h98badcfe;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    // buffer write sources
    localparam logic [1:0] WR_NONE = 2'd0;
    localparam logic [1:0] WR_DATA = 2'd1;
    localparam logic [1:0] WR_PAD  = 2'd2;

    typedef struct packed {
        logic [1:0] wr_sel;
        logic       pad_clear;   // zero-fill bytes past the marker
        logic       clear_all;   // zero words 0 to 13 for a length-only block
        logic       put_len;     // write bit length into words 14 and 15
        logic       count_byte;
        logic       start_block;
        logic       round_step;
        logic       fold;        // add working words into chaining value
        logic       reinit;
    } md5_cmd_t;

    typedef struct packed {
        logic [5:0] pos;
        logic       last_round;
    } md5_status_t;

    function automatic logic [31:0] sine_k(input logic [5:0] j);
        logic [31:0] t [64];
        t = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
        32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
        32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
        32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
        32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
        32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
        return t[j];
    endfunction

    function automatic logic [4:0] shift_s(input logic [5:0] j);
        logic [4:0] r;
        case ({j[5:4], j[1:0]})
            4'h0: r = 5'd7;   4'h1: r = 5'd12;  4'h2: r = 5'd17;  4'h3: r = 5'd22;
            4'h4: r = 5'd5;   4'h5: r = 5'd9;   4'h6: r = 5'd14;  4'h7: r = 5'd20;
            4'h8: r = 5'd4;   4'h9: r = 5'd11;  4'ha: r = 5'd16;  4'hb: r = 5'd23;
            4'hc: r = 5'd6;   4'hd: r = 5'd10;  4'he: r = 5'd15;  4'hf: r = 5'd21;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

>>> src/md5_streaming_digest_top.sv
// streaming md5 digest
// input channel: one transfer carries data_byte, byte_valid and end_of_message;
//   byte_valid low with end_of_message high ends a message with no new byte
// a byte that completes a 64-byte block starts 64 rounds at one round per cycle
//   in a single shared round unit; input stays stalled through the rounds and the fold
// end of message pads one or two blocks; the first digest transfer follows the
//   fold of the last block: half_index 0 (bytes 0..7) then
//   half_index 1 (bytes 8..15, last_of_run high); first byte sits in bits 7..0
// other bytes are taken without a stall, so throughput is one byte per cycle
//   outside block processing, padding and digest output
// output stall holds the current half; input stays stalled until both halves
//   are taken, after which the chaining value and bit count reinitialize
// reset loads the standard initial words and clears the count; the block
//   buffer has no reset and every byte is written before a block runs
module md5_streaming_digest_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] digest_half,
    output logic        half_index,
    output logic        last_of_run
);

    md5_pkg::md5_cmd_t    cmd;
    md5_pkg::md5_status_t status;
    logic [127:0]         digest;
    logic                 half_sel;

    md5_ctrl u_ctrl
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .byte_valid     (byte_valid),
        .end_of_message (end_of_message),
        .status         (status),
        .cmd            (cmd),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .half_sel       (half_sel)
    );

    md5_datapath u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .data_byte (data_byte),
        .status    (status),
        .digest    (digest)
    );

    assign digest_half = half_sel ? digest[127:64] : digest[63:0];
    assign half_index = half_sel;
    assign last_of_run = half_sel;

endmodule

>>> src/md5_datapath.sv
module md5_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  md5_pkg::md5_cmd_t   cmd,
    input  logic [7:0]          data_byte,
    output md5_pkg::md5_status_t status,
    output logic [127:0]        digest
);

    logic [31:0]  buf_reg [16];
    logic [31:0]  cv_reg [4];
    logic [31:0]  a_reg, b_reg, c_reg, d_reg;
    logic [63:0]  bit_count_reg;
    logic [5:0]   round_reg;
    logic [5:0]   pos;
    logic [3:0]   k;
    logic [31:0]  f, t, rot;
    logic [4:0]   s;

    assign pos = bit_count_reg[8:3];
    assign status.pos = pos;
    assign status.last_round = (round_reg == 6'd63);
    assign digest = {cv_reg[3], cv_reg[2], cv_reg[1], cv_reg[0]};

    always_comb
    begin
        case (round_reg[5:4])
            2'd0:
            begin
                f = (b_reg & c_reg) | (~b_reg & d_reg);
                k = round_reg[3:0];
            end
            2'd1:
            begin
                f = (b_reg & d_reg) | (c_reg & ~d_reg);
                k = 4'(round_reg[3:0] * 4'd5 + 4'd1);
            end
            2'd2:
            begin
                f = b_reg ^ c_reg ^ d_reg;
                k = 4'(round_reg[3:0] * 4'd3 + 4'd5);
            end
            default:
            begin
                f = c_reg ^ (b_reg | ~d_reg);
                k = 4'(round_reg[3:0] * 4'd7);
            end
        endcase
        t = a_reg + f + buf_reg[k] + md5_pkg::sine_k(round_reg);
        s = md5_pkg::shift_s(round_reg);
        rot = (t << s) | (t >> (6'd32 - {1'b0, s}));
    end

    // block buffer: byte writes, zero fill and length insert
    always_ff @(posedge clk)
    begin
        for (int w = 0; w < 16; w++)
        begin
            for (int bi = 0; bi < 4; bi++)
            begin
                if (cmd.pad_clear && ((w * 4 + bi) > int'(pos)))
                begin
                    buf_reg[w][bi*8 +: 8] <= 8'h00;
                end
            end
        end
        if (cmd.clear_all)
        begin
            for (int w = 0; w < 14; w++)
            begin
                buf_reg[w] <= '0;
            end
        end
        if (cmd.wr_sel == md5_pkg::WR_DATA)
        begin
            buf_reg[pos[5:2]][pos[1:0]*8 +: 8] <= data_byte;
        end
        else if (cmd.wr_sel == md5_pkg::WR_PAD)
        begin
            buf_reg[pos[5:2]][pos[1:0]*8 +: 8] <= md5_pkg::PAD_BYTE;
        end
        if (cmd.put_len)
        begin
            buf_reg[14] <= bit_count_reg[31:0];
            buf_reg[15] <= bit_count_reg[63:32];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg[0] <= md5_pkg::IV0;
            cv_reg[1] <= md5_pkg::IV1;
            cv_reg[2] <= md5_pkg::IV2;
            cv_reg[3] <= md5_pkg::IV3;
            a_reg <= '0; b_reg <= '0; c_reg <= '0; d_reg <= '0;
            bit_count_reg <= '0;
            round_reg <= '0;
        end
        else
        begin
            if (cmd.count_byte)
            begin
                bit_count_reg <= bit_count_reg + 64'd8;
            end
            if (cmd.start_block)
            begin
                a_reg <= cv_reg[0]; b_reg <= cv_reg[1];
                c_reg <= cv_reg[2]; d_reg <= cv_reg[3];
                round_reg <= '0;
            end
            else if (cmd.round_step)
            begin
                a_reg <= d_reg;
                b_reg <= b_reg + rot;
                c_reg <= b_reg;
                d_reg <= c_reg;
                round_reg <= round_reg + 6'd1;
            end
            if (cmd.fold)
            begin
                cv_reg[0] <= cv_reg[0] + a_reg;
                cv_reg[1] <= cv_reg[1] + b_reg;
                cv_reg[2] <= cv_reg[2] + c_reg;
                cv_reg[3] <= cv_reg[3] + d_reg;
            end
            if (cmd.reinit)
            begin
                cv_reg[0] <= md5_pkg::IV0;
                cv_reg[1] <= md5_pkg::IV1;
                cv_reg[2] <= md5_pkg::IV2;
                cv_reg[3] <= md5_pkg::IV3;
                bit_count_reg <= '0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_count_in_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.round_step |-> !cmd.count_byte)
        else $error("byte counted during rounds");
    a_round_adv: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.round_step && !cmd.start_block |=> round_reg == $past(round_reg) + 6'd1)
        else $error("round counter skipped");
    a_fold_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fold |-> round_reg == 6'd0 && $past(round_reg) == 6'd63)
        else $error("fold without full block");
`endif

endmodule

>>> src/md5_ctrl.sv
module md5_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 byte_valid,
    input  logic                 end_of_message,
    input  md5_pkg::md5_status_t status,
    output md5_pkg::md5_cmd_t    cmd,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 half_sel
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RUN   = 3'd1;
    localparam logic [2:0] S_PAD   = 3'd2;
    localparam logic [2:0] S_OUT0  = 3'd3;
    localparam logic [2:0] S_OUT1  = 3'd4;
    localparam logic [2:0] S_FOLD  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       end_reg, end_next;     // message end pending
    logic       lenblk_reg, lenblk_next; // running block is the length block
    logic       padded_reg, padded_next; // marker already placed
    logic       acc;

    assign in_stall = (state_reg != S_IDLE);
    assign acc = in_valid && !in_stall;
    assign out_valid = (state_reg == S_OUT0) || (state_reg == S_OUT1);
    assign half_sel = (state_reg == S_OUT1);

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        end_next = end_reg;
        lenblk_next = lenblk_reg;
        padded_next = padded_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    padded_next = 1'b0;
                    lenblk_next = 1'b0;
                    end_next = end_of_message;
                    if (byte_valid)
                    begin
                        cmd.wr_sel = md5_pkg::WR_DATA;
                        cmd.count_byte = 1'b1;
                        if (status.pos == 6'd63)
                        begin
                            cmd.start_block = 1'b1;
                            state_next = S_RUN;
                        end
                        else if (end_of_message)
                        begin
                            state_next = S_PAD;
                        end
                    end
                    else if (end_of_message)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                // count already final; place marker once, then the length in this block or the next
                if (!padded_reg)
                begin
                    cmd.wr_sel = md5_pkg::WR_PAD;
                    cmd.pad_clear = 1'b1;
                    padded_next = 1'b1;
                    if (status.pos >= 6'd56)
                    begin
                        cmd.start_block = 1'b1;
                        state_next = S_RUN;
                    end
                end
                else
                begin
                    // marker placed: add length; zero words 0..13 if marker went in the prior block
                    cmd.clear_all = (status.pos >= 6'd56);
                    cmd.put_len = 1'b1;
                    lenblk_next = 1'b1;
                    cmd.start_block = 1'b1;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                cmd.round_step = 1'b1;
                if (status.last_round)
                begin
                    state_next = S_FOLD;
                end
            end
            S_FOLD:
            begin
                // working words are final here
                cmd.fold = 1'b1;
                state_next = S_IDLE;
                if (end_reg)
                begin
                    state_next = lenblk_reg ? S_OUT0 : S_PAD;
                end
            end
            S_OUT0:
            begin
                if (!out_stall)
                begin
                    state_next = S_OUT1;
                end
            end
            S_OUT1:
            begin
                if (!out_stall)
                begin
                    cmd.reinit = 1'b1;
                    end_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            end_reg <= 1'b0;
            lenblk_reg <= 1'b0;
            padded_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            end_reg <= end_next;
            lenblk_reg <= lenblk_next;
            padded_reg <= padded_next;
        end
    end

`ifndef ASSERT_OFF
    a_out_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT1 |-> $past(state_reg) == S_OUT0 || $past(state_reg) == S_OUT1)
        else $error("second half without first");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RUN |-> in_stall)
        else $error("input taken during rounds");
    a_fold_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FOLD |-> $past(state_reg) == S_RUN)
        else $error("fold without rounds");
`endif

endmodule

>>> verif/tb_md5_streaming_digest_top.sv
module tb_md5_streaming_digest_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam int ROT_AMT [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                    4, 11, 16, 23, 6, 10, 15, 21};

    typedef struct {
        logic [63:0] digest_half;
        logic        half_index;
        logic        last_of_run;
    } digest_beat_t;

    class md5_scoreboard;
        logic [31:0]  chain [4];
        logic [7:0]   block_bytes [64];
        logic [63:0]  bit_count;
        digest_beat_t digest_q [$];
        int           errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            chain[0] = md5_pkg::IV0;
            chain[1] = md5_pkg::IV1;
            chain[2] = md5_pkg::IV2;
            chain[3] = md5_pkg::IV3;
            bit_count = '0;
        endfunction

        function logic [31:0] rotl(logic [31:0] x, int s);
            return (s == 0) ? x : ((x << s) | (x >> (32 - s)));
        endfunction

        function void compress();
            logic [31:0] w [16];
            logic [31:0] a, b, c, d, f, t;
            int k;
            for (int i = 0; i < 16; i++)
                w[i] = {block_bytes[4*i+3], block_bytes[4*i+2],
                        block_bytes[4*i+1], block_bytes[4*i]};
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            for (int j = 0; j < 64; j++)
            begin
                case (j / 16)
                    0: begin f = (b & c) | (~b & d); k = j; end
                    1: begin f = (b & d) | (c & ~d); k = (5 * j + 1) % 16; end
                    2: begin f = b ^ c ^ d; k = (3 * j + 5) % 16; end
                    default: begin f = c ^ (b | ~d); k = (7 * j) % 16; end
                endcase
                t = a + f + w[k] + ROUND_K[j];
                t = b + rotl(t, ROT_AMT[(j / 16) * 4 + (j % 4)]);
                a = d;
                d = c;
                c = b;
                b = t;
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
        endfunction

        // one accepted input transfer
        function void note_input(logic [7:0] data, logic valid, logic eom);
            int pos;
            logic [63:0] len;
            digest_beat_t beat;
            if (valid)
            begin
                pos = bit_count[8:3];
                block_bytes[pos] = data;
                bit_count += 64'd8;
                if (pos == 63)
                    compress();
            end
            if (eom)
            begin
                len = bit_count;
                pos = len[8:3];
                block_bytes[pos] = md5_pkg::PAD_BYTE;
                pos++;
                if (pos > 56)
                begin
                    while (pos < 64)
                        block_bytes[pos++] = 8'h00;
                    compress();
                    pos = 0;
                end
                while (pos < 56)
                    block_bytes[pos++] = 8'h00;
                for (int i = 0; i < 8; i++)
                    block_bytes[56 + i] = len[8*i +: 8];
                compress();
                beat.digest_half = {chain[1], chain[0]};
                beat.half_index = 1'b0;
                beat.last_of_run = 1'b0;
                digest_q.push_back(beat);
                beat.digest_half = {chain[3], chain[2]};
                beat.half_index = 1'b1;
                beat.last_of_run = 1'b1;
                digest_q.push_back(beat);
                restart();
            end
        endfunction

        function void check_result(logic [63:0] dh, logic hi, logic lr);
            digest_beat_t exp_beat;
            if (digest_q.size() == 0)
            begin
                $error("unexpected digest transfer: digest_half %h", dh);
                errors++;
                return;
            end
            exp_beat = digest_q.pop_front();
            if (dh !== exp_beat.digest_half)
            begin
                $error("digest_half expected %h actual %h", exp_beat.digest_half, dh);
                errors++;
            end
            if (hi !== exp_beat.half_index)
            begin
                $error("half_index expected %0d actual %0d", exp_beat.half_index, hi);
                errors++;
            end
            if (lr !== exp_beat.last_of_run)
            begin
                $error("last_of_run expected %0d actual %0d", exp_beat.last_of_run, lr);
                errors++;
            end
        endfunction

        function int pending();
            return digest_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        end_of_message;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] digest_half;
    logic        half_index;
    logic        last_of_run;

    md5_scoreboard sb;
    int            sent_items;

    md5_streaming_digest_top DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .byte_valid     (byte_valid),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .digest_half    (digest_half),
        .half_index     (half_index),
        .last_of_run    (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic send_item(input logic [7:0] b, input logic v, input logic e);
        @(negedge clk);
        in_valid <= 1'b1;
        data_byte <= b;
        byte_valid <= v;
        end_of_message <= e;
        do @(posedge clk); while (in_stall);
        sb.note_input(b, v, e);
        if (v || e)
            sent_items++;
    endtask

    task automatic idle_gap(input int n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            data_byte <= 8'($urandom);
            byte_valid <= 1'($urandom);
            end_of_message <= 1'($urandom);
        end
    endtask

    // the last transfer must not be offered again while waiting
    task automatic drain_digests();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // one message; sometimes the end rides on the last byte, sometimes on a bare marker
    task automatic send_message(input int len);
        logic bare_end;
        int burst;
        bare_end = (len == 0) || ($urandom_range(0, 1) == 0);
        burst = $urandom_range(1, 30);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, (i == len - 1) && !bare_end);
            if (--burst == 0)
            begin
                idle_gap($urandom_range(0, 10));
                burst = $urandom_range(1, 30);
            end
        end
        if (bare_end)
            send_item(8'($urandom), 1'b0, 1'b1);
        idle_gap($urandom_range(0, 4));
    endtask

    // receiver stall pattern
    initial
    begin
        int mode;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(20, 300))
            begin
                @(negedge clk);
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 2) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= 1'b1;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(digest_half, half_index, last_of_run);
    end

    initial
    begin
        int len;
        sb = new();
        sent_items = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = 8'h00;
        byte_valid = 1'b0;
        end_of_message = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: idle transfer, empty message, extreme bytes, short messages
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'haa, 1'b1, 1'b0);
        send_item(8'h55, 1'b0, 1'b1);
        send_item(8'h00, 1'b0, 1'b1);
        drain_digests();

        // padding boundaries: one pad block versus two, full block
        send_message(55);
        send_message(56);
        send_message(64);
        drain_digests();

        while (sent_items < 750)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: len = $urandom_range(0, 20);
                6, 7: len = $urandom_range(50, 70);
                8: len = $urandom_range(110, 135);
                default: len = $urandom_range(1, 3);
            endcase
            send_message(len);
            if ($urandom_range(0, 15) == 0)
                drain_digests();
        end
        @(negedge clk);
        in_valid <= 1'b0;
        drain_digests();
        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

>>> md5_streaming_digest_top.f
src/md5_pkg.sv
src/md5_datapath.sv
src/md5_ctrl.sv
src/md5_streaming_digest_top.sv
verif/tb_md5_streaming_digest_top.sv
